@@ rtl/lfm_pkg.sv @@
// Package: shared types, constants and saturating Q32.32 helpers for the lateral force pipeline.
package lfm_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int HSHIFT_BASE_DEF = 0;
  localparam int HSHIFT_LOAD_DEF = 0;
  localparam int VSHIFT_LINEAR_DEF = 0;
  localparam int VSHIFT_QUADRATIC_DEF = 0;

  localparam int RED_N = 29;
  localparam int DIV_BITS = 96;

  localparam logic signed [63:0] Q_ONE = 64'sh1_0000_0000;
  localparam logic signed [63:0] Q_PI = 64'sh3_243F_6A89;
  localparam logic signed [63:0] Q_HALF_PI = 64'sh1_921F_B544;
  localparam logic signed [63:0] Q_TWO_PI = 64'sh6_487E_D511;
  localparam logic signed [63:0] Q_GAIN_INV = 64'sh9B74_EDA8;
  localparam logic signed [63:0] Q_GUARD = 64'sd4294967;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  localparam logic signed [63:0] ATAN_HEAD [11] = '{
    64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
    64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
    64'sd16777131, 64'sd8388597, 64'sd4194303
  };

  typedef enum logic [2:0] {
    REG_SHAPE_FACTOR = 3'd0,
    REG_PEAK_LINEAR = 3'd1,
    REG_PEAK_QUADRATIC = 3'd2,
    REG_CURVATURE_BASE = 3'd3,
    REG_CURVATURE_LOAD = 3'd4,
    REG_CURVATURE_SIGN = 3'd5,
    REG_STIFFNESS_PEAK = 3'd6,
    REG_STIFFNESS_LOAD_SCALE = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic sat;
    logic signed [63:0] v;
  } qv_t;

  typedef struct packed {
    logic signed [31:0] vertical_load;
    logic signed [31:0] slip_angle;
    logic last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] lateral_force;
    logic saturated;
    logic last_out;
  } out_word_t;

  function automatic logic signed [63:0] step_angle(int i);
    if (i < 11) begin
      return ATAN_HEAD[i];
    end else if (i <= 32) begin
      return 64'sd1 <<< (32 - i);
    end
    return 64'sd0;
  endfunction

  function automatic int lat_total(int steps);
    return 114 + 2 * (RED_N + 2) + 5 * steps;
  endfunction

  function automatic qv_t from_mag(logic [63:0] m, logic neg, logic ovf, logic sat_in);
    qv_t r;
    r.sat = sat_in;
    if (neg) begin
      if (ovf || m > 64'h8000_0000_0000_0000) begin
        r.v = Q_MIN;
        r.sat = 1'b1;
      end else begin
        r.v = 64'(64'd0 - m);
      end
    end else if (ovf || m[63]) begin
      r.v = Q_MAX;
      r.sat = 1'b1;
    end else begin
      r.v = m;
    end
    return r;
  endfunction

  function automatic qv_t sadd(qv_t a, qv_t b);
    qv_t r;
    r.v = a.v + b.v;
    r.sat = a.sat | b.sat;
    if (!a.v[63] && !b.v[63] && r.v[63]) begin
      r.v = Q_MAX;
      r.sat = 1'b1;
    end else if (a.v[63] && b.v[63] && !r.v[63]) begin
      r.v = Q_MIN;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  function automatic qv_t sneg(qv_t a);
    qv_t r;
    r.sat = a.sat;
    if (a.v == Q_MIN) begin
      r.v = Q_MAX;
      r.sat = 1'b1;
    end else begin
      r.v = -a.v;
    end
    return r;
  endfunction

  function automatic qv_t ssub(qv_t a, qv_t b);
    return sadd(a, sneg(b));
  endfunction

  function automatic qv_t widen(logic signed [31:0] f);
    qv_t r;
    r.sat = 1'b0;
    r.v = {{16{f[31]}}, f, 16'h0000};
    return r;
  endfunction

endpackage

@@ rtl/lfm_delay.sv @@
// Module: fixed-length shift register that keeps side words aligned with the pipeline.
module lfm_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        sr_r[i] <= '0;
      end
    end else begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

@@ rtl/lfm_mul.sv @@
// Module: two-stage saturating Q32.32 multiplier built from four 32x32 partial products.
module lfm_mul (
  input  logic           clk,
  input  lfm_pkg::qv_t   a,
  input  lfm_pkg::qv_t   b,
  output lfm_pkg::qv_t   p
);

  logic [63:0] xa, yb;
  logic [63:0] ll_r, lh_r, hl_r, hh_r;
  logic        neg_r, sat_r;
  logic [63:0] mid, hi;
  lfm_pkg::qv_t p_r;

  assign xa = a.v[63] ? 64'(64'd0 - a.v) : a.v;
  assign yb = b.v[63] ? 64'(64'd0 - b.v) : b.v;

  always_ff @(posedge clk) begin
    ll_r  <= 64'(xa[31:0] * yb[31:0]);
    lh_r  <= 64'(xa[31:0] * yb[63:32]);
    hl_r  <= 64'(xa[63:32] * yb[31:0]);
    hh_r  <= 64'(xa[63:32] * yb[63:32]);
    neg_r <= a.v[63] ^ b.v[63];
    sat_r <= a.sat | b.sat;
  end

  assign mid = {32'h0, ll_r[63:32]} + {32'h0, lh_r[31:0]} + {32'h0, hl_r[31:0]};
  assign hi = hh_r + {32'h0, lh_r[63:32]} + {32'h0, hl_r[63:32]} + {32'h0, mid[63:32]};

  always_ff @(posedge clk) begin
    p_r <= lfm_pkg::from_mag({hi[31:0], mid[31:0]}, neg_r, |hi[63:32], sat_r);
  end

  assign p = p_r;

endmodule

@@ rtl/lfm_atan.sv @@
// Module: pipelined CORDIC arctangent in vectoring mode, one iteration per stage.
module lfm_atan #(
  parameter int STEPS = lfm_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  lfm_pkg::qv_t t,
  output lfm_pkg::qv_t z
);

  lfm_pkg::qv_t x_r [STEPS];
  lfm_pkg::qv_t y_r [STEPS];
  logic signed [63:0] z_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    localparam logic signed [63:0] ANG = lfm_pkg::step_angle(i);
    lfm_pkg::qv_t px, py, dxq, dyq;
    logic signed [63:0] pz;

    if (i == 0) begin : g_first
      assign px = '{sat: 1'b0, v: lfm_pkg::Q_ONE >>> 2};
      assign py = '{sat: t.sat, v: t.v >>> 2};
      assign pz = 64'sd0;
    end else begin : g_next
      assign px = x_r[i-1];
      assign py = y_r[i-1];
      assign pz = z_r[i-1];
    end

    assign dxq = '{sat: 1'b0, v: py.v >>> i};
    assign dyq = '{sat: 1'b0, v: px.v >>> i};

    always_ff @(posedge clk) begin
      if (!py.v[63]) begin
        x_r[i] <= lfm_pkg::sadd(px, dxq);
        y_r[i] <= lfm_pkg::ssub(py, dyq);
        z_r[i] <= pz + ANG;
      end else begin
        x_r[i] <= lfm_pkg::ssub(px, dxq);
        y_r[i] <= lfm_pkg::sadd(py, dyq);
        z_r[i] <= pz - ANG;
      end
    end
  end

  assign z = '{sat: x_r[STEPS-1].sat | y_r[STEPS-1].sat, v: z_r[STEPS-1]};

endmodule

@@ rtl/lfm_sin.sv @@
// Module: pipelined sine with range reduction by 2*pi, quadrant fold and CORDIC rotation.
module lfm_sin #(
  parameter int STEPS = lfm_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  lfm_pkg::qv_t a,
  output lfm_pkg::qv_t s
);

  localparam int RN = lfm_pkg::RED_N;

  logic [63:0] mag_r [RN];
  logic        neg_r [RN];
  logic        sat_r [RN];
  logic signed [63:0] w1_r, w2_r;
  logic        sw1_r, sw2_r;
  logic signed [63:0] r1, r1w, r2;
  lfm_pkg::qv_t x_r [STEPS];
  lfm_pkg::qv_t y_r [STEPS];
  logic signed [63:0] z_r [STEPS];

  for (genvar j = 0; j < RN; j++) begin : g_red
    localparam logic [63:0] SUBV = 64'(lfm_pkg::Q_TWO_PI) << (RN - 1 - j);
    logic [63:0] pm;
    logic        pn, ps;
    if (j == 0) begin : g_first
      assign pm = a.v[63] ? 64'(64'd0 - a.v) : a.v;
      assign pn = a.v[63];
      assign ps = a.sat;
    end else begin : g_next
      assign pm = mag_r[j-1];
      assign pn = neg_r[j-1];
      assign ps = sat_r[j-1];
    end
    always_ff @(posedge clk) begin
      mag_r[j] <= (pm >= SUBV) ? pm - SUBV : pm;
      neg_r[j] <= pn;
      sat_r[j] <= ps;
    end
  end

  always_comb begin
    r1 = neg_r[RN-1] ? -$signed(mag_r[RN-1]) : $signed(mag_r[RN-1]);
    r1w = r1;
    if (r1 > lfm_pkg::Q_PI) begin
      r1w = r1 - lfm_pkg::Q_TWO_PI;
    end else if (r1 < -lfm_pkg::Q_PI) begin
      r1w = r1 + lfm_pkg::Q_TWO_PI;
    end
  end

  always_comb begin
    r2 = w1_r;
    if (w1_r > lfm_pkg::Q_HALF_PI) begin
      r2 = lfm_pkg::Q_PI - w1_r;
    end else if (w1_r < -lfm_pkg::Q_HALF_PI) begin
      r2 = -lfm_pkg::Q_PI - w1_r;
    end
  end

  always_ff @(posedge clk) begin
    w1_r  <= r1w;
    sw1_r <= sat_r[RN-1];
    w2_r  <= r2;
    sw2_r <= sw1_r;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    localparam logic signed [63:0] ANG = lfm_pkg::step_angle(i);
    lfm_pkg::qv_t px, py, dxq, dyq;
    logic signed [63:0] pz;

    if (i == 0) begin : g_first
      assign px = '{sat: 1'b0, v: lfm_pkg::Q_GAIN_INV};
      assign py = '{sat: sw2_r, v: 64'sd0};
      assign pz = w2_r;
    end else begin : g_next
      assign px = x_r[i-1];
      assign py = y_r[i-1];
      assign pz = z_r[i-1];
    end

    assign dxq = '{sat: 1'b0, v: py.v >>> i};
    assign dyq = '{sat: 1'b0, v: px.v >>> i};

    always_ff @(posedge clk) begin
      if (!pz[63]) begin
        x_r[i] <= lfm_pkg::ssub(px, dxq);
        y_r[i] <= lfm_pkg::sadd(py, dyq);
        z_r[i] <= pz - ANG;
      end else begin
        x_r[i] <= lfm_pkg::sadd(px, dxq);
        y_r[i] <= lfm_pkg::ssub(py, dyq);
        z_r[i] <= pz + ANG;
      end
    end
  end

  assign s = '{sat: x_r[STEPS-1].sat | y_r[STEPS-1].sat, v: y_r[STEPS-1].v};

endmodule

@@ rtl/lfm_div.sv @@
// Module: pipelined restoring divider producing a saturated Q32.32 quotient, one bit per stage.
module lfm_div (
  input  logic         clk,
  input  lfm_pkg::qv_t n,
  input  lfm_pkg::qv_t d,
  output lfm_pkg::qv_t q
);

  localparam int NB = lfm_pkg::DIV_BITS;

  logic [63:0] r_r   [NB];
  logic [63:0] q_r   [NB];
  logic [63:0] num_r [NB];
  logic [63:0] den_r [NB];
  logic        ovf_r [NB];
  logic        neg_r [NB];
  logic        sat_r [NB];
  lfm_pkg::qv_t q_out_r;

  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam int K = NB - 1 - j;
    logic [63:0] pr, pq, pnum, pden, rs;
    logic        povf, pneg, psat, bitv, take;

    if (j == 0) begin : g_first
      assign pr = '0;
      assign pq = '0;
      assign pnum = n.v[63] ? 64'(64'd0 - n.v) : n.v;
      assign pden = d.v[63] ? 64'(64'd0 - d.v) : d.v;
      assign povf = 1'b0;
      assign pneg = n.v[63] ^ d.v[63];
      assign psat = n.sat | d.sat;
    end else begin : g_next
      assign pr = r_r[j-1];
      assign pq = q_r[j-1];
      assign pnum = num_r[j-1];
      assign pden = den_r[j-1];
      assign povf = ovf_r[j-1];
      assign pneg = neg_r[j-1];
      assign psat = sat_r[j-1];
    end

    if (K >= 32) begin : g_num
      assign bitv = pnum[K-32];
    end else begin : g_zero
      assign bitv = 1'b0;
    end

    assign rs = {pr[62:0], bitv};
    assign take = pr[63] || (rs >= pden);

    always_ff @(posedge clk) begin
      r_r[j]   <= take ? rs - pden : rs;
      q_r[j]   <= {pq[62:0], take};
      ovf_r[j] <= povf | pq[63];
      num_r[j] <= pnum;
      den_r[j] <= pden;
      neg_r[j] <= pneg;
      sat_r[j] <= psat;
    end
  end

  always_ff @(posedge clk) begin
    q_out_r <= lfm_pkg::from_mag(q_r[NB-1], neg_r[NB-1], ovf_r[NB-1], sat_r[NB-1]);
  end

  assign q = q_out_r;

endmodule

@@ rtl/tire_lateral_force_magic_formula_top.sv @@
// Top level: pipelined pure-slip lateral tire force evaluator by the magic formula.
//
//   channel  ports                              handshake
//   input    start, busy, in_data               word taken when start && !busy
//   result   out_valid, out_data                one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_addr, cfg_wdata        write when cfg_we is high
//
// A word is taken in every cycle that start is high; busy is always low.
// Latency is set by the chain of three arctangent and two
// sine CORDIC pipelines, the 96-stage divider and the multipliers between them.
// Reset clears the configuration registers and the valid pipeline.
// The result side cannot stall, so the pipeline always advances.
module tire_lateral_force_magic_formula_top #(
  parameter int CORDIC_STEPS = lfm_pkg::CORDIC_STEPS_DEF,
  parameter int HSHIFT_BASE = lfm_pkg::HSHIFT_BASE_DEF,
  parameter int HSHIFT_LOAD = lfm_pkg::HSHIFT_LOAD_DEF,
  parameter int VSHIFT_LINEAR = lfm_pkg::VSHIFT_LINEAR_DEF,
  parameter int VSHIFT_QUADRATIC = lfm_pkg::VSHIFT_QUADRATIC_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lfm_pkg::in_word_t   in_data,
  output logic                out_valid,
  output lfm_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [63:0]         cfg_wdata
);

  localparam int QW = $bits(lfm_pkg::qv_t);
  localparam int LM = 2;
  localparam int LA = CORDIC_STEPS;
  localparam int LS = lfm_pkg::RED_N + 2 + CORDIC_STEPS;
  localparam int LD = lfm_pkg::DIV_BITS + 1;
  localparam int T_FZ = 1;
  localparam int T_P = T_FZ + LM;
  localparam int T_AY = T_P + 1;
  localparam int T_FAC = T_AY + 1;
  localparam int T_SVDY = T_FAC + 1;
  localparam int T_EY = T_FAC + LM;
  localparam int T_G = T_SVDY + LM + 1;
  localparam int T_AT1 = T_P + LA;
  localparam int T_S1 = T_AT1 + LS;
  localparam int T_KY = T_S1 + LM;
  localparam int T_BY = T_KY + LD;
  localparam int T_T = T_BY + LM;
  localparam int T_AT2 = T_T + LA;
  localparam int T_D = T_AT2 + 1;
  localparam int T_M = T_D + LM;
  localparam int T_IN = T_M + 1;
  localparam int T_AT3 = T_IN + LA;
  localparam int T_G2 = T_AT3 + LM;
  localparam int T_S2 = T_G2 + LS;
  localparam int T_F = T_S2 + LM;
  localparam int T_FY = T_F + 1;
  localparam int T_OUT = T_FY + 1;

  localparam logic signed [63:0] HB_Q = 64'(HSHIFT_BASE) * 64'sd65536;
  localparam logic signed [63:0] HL_Q = 64'(HSHIFT_LOAD) * 64'sd65536;
  localparam logic signed [63:0] VL_Q = 64'(VSHIFT_LINEAR) * 64'sd65536;
  localparam logic signed [63:0] VQ_Q = 64'(VSHIFT_QUADRATIC) * 64'sd65536;

  logic [63:0] cfg_r [8];
  lfm_pkg::qv_t c_q, pl_q, pq_q, cb_q, cl_q, cs_q, sp_q, ss_q;
  lfm_pkg::qv_t hb_q, hl_q, vl_q, vq_q, one_q, grd_pos, grd_neg;
  lfm_pkg::qv_t fz_r, alpha_r, alpha_d;
  lfm_pkg::qv_t fz2, p_hl, p_vl, p_pl, p_cl, p_sl, p_vl_d, p_pl_d;
  lfm_pkg::qv_t ay_r, eya_r, eya_d, fac_r, m_vq, m_pq, sv_r, dy_r, ey;
  lfm_pkg::qv_t tmp, grd_r, grd_d, at1, at1x2, s1, ky, by_q, ay_d, t_q, at2;
  lfm_pkg::qv_t t_d1, t_d2, d_r, ey_d, m_q, inner_r, at3, g_q, s2, dy_d, f_q, sv_d, fy_r;
  logic [1:0] vl_d;
  logic signed [63:0] f_sh;
  lfm_pkg::out_word_t out_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_r[cfg_addr] <= cfg_wdata;
    end
  end

  assign c_q  = '{sat: 1'b0, v: cfg_r[lfm_pkg::REG_SHAPE_FACTOR]};
  assign pl_q = '{sat: 1'b0, v: cfg_r[lfm_pkg::REG_PEAK_LINEAR]};
  assign pq_q = '{sat: 1'b0, v: cfg_r[lfm_pkg::REG_PEAK_QUADRATIC]};
  assign cb_q = '{sat: 1'b0, v: cfg_r[lfm_pkg::REG_CURVATURE_BASE]};
  assign cl_q = '{sat: 1'b0, v: cfg_r[lfm_pkg::REG_CURVATURE_LOAD]};
  assign cs_q = '{sat: 1'b0, v: cfg_r[lfm_pkg::REG_CURVATURE_SIGN]};
  assign sp_q = '{sat: 1'b0, v: cfg_r[lfm_pkg::REG_STIFFNESS_PEAK]};
  assign ss_q = '{sat: 1'b0, v: cfg_r[lfm_pkg::REG_STIFFNESS_LOAD_SCALE]};
  assign hb_q = '{sat: 1'b0, v: HB_Q};
  assign hl_q = '{sat: 1'b0, v: HL_Q};
  assign vl_q = '{sat: 1'b0, v: VL_Q};
  assign vq_q = '{sat: 1'b0, v: VQ_Q};
  assign one_q = '{sat: 1'b0, v: lfm_pkg::Q_ONE};
  assign grd_pos = '{sat: 1'b0, v: lfm_pkg::Q_GUARD};
  assign grd_neg = '{sat: 1'b0, v: -lfm_pkg::Q_GUARD};

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    fz_r    <= lfm_pkg::widen(in_data.vertical_load);
    alpha_r <= lfm_pkg::widen(in_data.slip_angle);
  end

  lfm_mul u_fz2 (.clk(clk), .a(fz_r), .b(fz_r), .p(fz2));
  lfm_mul u_phl (.clk(clk), .a(hl_q), .b(fz_r), .p(p_hl));
  lfm_mul u_pvl (.clk(clk), .a(vl_q), .b(fz_r), .p(p_vl));
  lfm_mul u_ppl (.clk(clk), .a(pl_q), .b(fz_r), .p(p_pl));
  lfm_mul u_pcl (.clk(clk), .a(cl_q), .b(fz_r), .p(p_cl));
  lfm_mul u_psl (.clk(clk), .a(ss_q), .b(fz_r), .p(p_sl));

  lfm_delay #(.W(QW), .N(T_P - T_FZ)) u_dl_alpha (
    .clk(clk), .rst_n(rst_n), .d(alpha_r), .q(alpha_d)
  );

  always_ff @(posedge clk) begin
    ay_r  <= lfm_pkg::sadd(lfm_pkg::sadd(alpha_d, p_hl), hb_q);
    eya_r <= lfm_pkg::sadd(p_cl, cb_q);
  end

  lfm_mul u_mvq (.clk(clk), .a(vq_q), .b(fz2), .p(m_vq));
  lfm_mul u_mpq (.clk(clk), .a(pq_q), .b(fz2), .p(m_pq));

  lfm_delay #(.W(QW), .N(T_FAC - T_P)) u_dl_pvl (
    .clk(clk), .rst_n(rst_n), .d(p_vl), .q(p_vl_d)
  );
  lfm_delay #(.W(QW), .N(T_FAC - T_P)) u_dl_ppl (
    .clk(clk), .rst_n(rst_n), .d(p_pl), .q(p_pl_d)
  );
  lfm_delay #(.W(QW), .N(T_FAC - T_AY)) u_dl_eya (
    .clk(clk), .rst_n(rst_n), .d(eya_r), .q(eya_d)
  );

  always_ff @(posedge clk) begin
    if (!ay_r.v[63] && ay_r.v != 64'sd0) begin
      fac_r <= lfm_pkg::ssub(one_q, cs_q);
    end else if (ay_r.v[63]) begin
      fac_r <= lfm_pkg::sadd(one_q, cs_q);
    end else begin
      fac_r <= one_q;
    end
    sv_r <= lfm_pkg::sadd(m_vq, p_vl_d);
    dy_r <= lfm_pkg::sadd(m_pq, p_pl_d);
  end

  lfm_mul u_ey (.clk(clk), .a(eya_d), .b(fac_r), .p(ey));
  lfm_mul u_tmp (.clk(clk), .a(c_q), .b(dy_r), .p(tmp));

  always_ff @(posedge clk) begin
    grd_r <= tmp.v[63] ? lfm_pkg::sadd(tmp, grd_neg) : lfm_pkg::sadd(tmp, grd_pos);
  end

  lfm_atan #(.STEPS(CORDIC_STEPS)) u_at1 (.clk(clk), .t(p_sl), .z(at1));
  assign at1x2 = '{sat: at1.sat, v: at1.v <<< 1};
  lfm_sin #(.STEPS(CORDIC_STEPS)) u_s1 (.clk(clk), .a(at1x2), .s(s1));
  lfm_mul u_ky (.clk(clk), .a(sp_q), .b(s1), .p(ky));

  lfm_delay #(.W(QW), .N(T_KY - T_G)) u_dl_grd (
    .clk(clk), .rst_n(rst_n), .d(grd_r), .q(grd_d)
  );

  lfm_div u_div (.clk(clk), .n(ky), .d(grd_d), .q(by_q));

  lfm_delay #(.W(QW), .N(T_BY - T_AY)) u_dl_ay (
    .clk(clk), .rst_n(rst_n), .d(ay_r), .q(ay_d)
  );

  lfm_mul u_t (.clk(clk), .a(by_q), .b(ay_d), .p(t_q));
  lfm_atan #(.STEPS(CORDIC_STEPS)) u_at2 (.clk(clk), .t(t_q), .z(at2));

  lfm_delay #(.W(QW), .N(T_AT2 - T_T)) u_dl_t1 (
    .clk(clk), .rst_n(rst_n), .d(t_q), .q(t_d1)
  );
  lfm_delay #(.W(QW), .N(T_M - T_T)) u_dl_t2 (
    .clk(clk), .rst_n(rst_n), .d(t_q), .q(t_d2)
  );
  lfm_delay #(.W(QW), .N(T_D - T_EY)) u_dl_ey (
    .clk(clk), .rst_n(rst_n), .d(ey), .q(ey_d)
  );

  always_ff @(posedge clk) begin
    d_r <= lfm_pkg::ssub(t_d1, at2);
  end

  lfm_mul u_m (.clk(clk), .a(ey_d), .b(d_r), .p(m_q));

  always_ff @(posedge clk) begin
    inner_r <= lfm_pkg::ssub(t_d2, m_q);
  end

  lfm_atan #(.STEPS(CORDIC_STEPS)) u_at3 (.clk(clk), .t(inner_r), .z(at3));
  lfm_mul u_g (.clk(clk), .a(c_q), .b(at3), .p(g_q));
  lfm_sin #(.STEPS(CORDIC_STEPS)) u_s2 (.clk(clk), .a(g_q), .s(s2));

  lfm_delay #(.W(QW), .N(T_S2 - T_SVDY)) u_dl_dy (
    .clk(clk), .rst_n(rst_n), .d(dy_r), .q(dy_d)
  );
  lfm_mul u_f (.clk(clk), .a(dy_d), .b(s2), .p(f_q));

  lfm_delay #(.W(QW), .N(T_F - T_SVDY)) u_dl_sv (
    .clk(clk), .rst_n(rst_n), .d(sv_r), .q(sv_d)
  );

  always_ff @(posedge clk) begin
    fy_r <= lfm_pkg::sadd(f_q, sv_d);
  end

  lfm_delay #(.W(2), .N(T_OUT - 1)) u_dl_vld (
    .clk(clk), .rst_n(rst_n), .d({start & ~busy, in_data.last_in}), .q(vl_d)
  );

  assign f_sh = fy_r.v >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vl_d[1];
    end
    out_r.last_out <= vl_d[0];
    if (f_sh > 64'sh7FFF_FFFF) begin
      out_r.lateral_force <= 32'sh7FFF_FFFF;
      out_r.saturated <= 1'b1;
    end else if (f_sh < -64'sh8000_0000) begin
      out_r.lateral_force <= 32'sh8000_0000;
      out_r.saturated <= 1'b1;
    end else begin
      out_r.lateral_force <= f_sh[31:0];
      out_r.saturated <= fy_r.sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

@@ rtl/lfm_checker.sv @@
// Checker: port-level assertions for the lateral force pipeline, bound to the top level.
module lfm_assertions #(
  parameter int STEPS = lfm_pkg::CORDIC_STEPS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input lfm_pkg::in_word_t  in_data,
  input logic               out_valid,
  input lfm_pkg::out_word_t out_data
);

  localparam int LAT = lfm_pkg::lat_total(STEPS);

  a_result_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a word taken at the pipeline latency");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_out == $past(in_data.last_in, LAT)))
    else $error("last marker does not match its word");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind tire_lateral_force_magic_formula_top lfm_assertions #(.STEPS(CORDIC_STEPS)) u_lfm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_data(out_data)
);
